[rtl/core/hsmc_pkg.sv]
// ----------------------------------------------------------------------------
// hsmc_pkg
// shared types, widths and constants of the heading steering motor commander
// ----------------------------------------------------------------------------
package hsmc_pkg;

    // field widths
    localparam int RAW_W   = 12;
    localparam int DEG_W   = 9;
    localparam int DIST_W  = 24;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 32;
    localparam int NEAR_W  = 16;
    localparam int SPD_W   = 7;
    localparam int MOTOR_W = 6;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 4;
    localparam int CDAT_W  = 32;
    localparam int INTEG_W = 48;
    localparam int ACC_W   = 44;
    localparam int PROD_W  = 64;
    localparam int TMAG_W  = 41;

    // fixed bytes and limits
    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h80;
    localparam logic [BYTE_W-1:0] DEVICE_BYTE = 8'h00;
    localparam logic [SPD_W-1:0]  SPEED_MAX   = 7'd127;
    localparam logic [TMAG_W-1:0] TERM_LIMIT  = 41'h100_0000_0000;

    // reciprocal of ten in Q16, exact for raw readings below 4096
    localparam logic [12:0] RECIP10 = 13'd6554;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_PROP_GAIN  = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_DERIV_GAIN = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_INTEG_GAIN = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_OFFSET     = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_NEAR_DIST  = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_NEAR_SPEED = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_FAR_SPEED  = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_FIRST_MOT  = 4'd7;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 32'd757584509;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 32'd1074;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN = 32'd107;
    localparam logic [DEG_W-1:0]   RST_OFFSET     = 9'd3;
    localparam logic [NEAR_W-1:0]  RST_NEAR_DIST  = 16'd5;
    localparam logic [SPD_W-1:0]   RST_NEAR_SPEED = 7'd35;
    localparam logic [SPD_W-1:0]   RST_FAR_SPEED  = 7'd127;
    localparam logic [MOTOR_W-1:0] RST_FIRST_MOT  = 6'd2;

    // byte position inside one motor packet
    localparam logic [1:0] POS_START  = 2'd0;
    localparam logic [1:0] POS_DEVICE = 2'd1;
    localparam logic [1:0] POS_MOTOR  = 2'd2;
    localparam logic [1:0] POS_SPEED  = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP     = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_TURN     = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_ERR,
        S_DECIDE,
        S_DIVD_GO,
        S_DIVD_WAIT,
        S_DIVQ_GO,
        S_DIVQ_WAIT,
        S_INTEG,
        S_MUL,
        S_SPEED,
        S_OUT
    } t_state;

endpackage

[rtl/core/hsmc_if.sv]
// ----------------------------------------------------------------------------
// hsmc_if
// channel interfaces: input items, result bytes and register writes
// ----------------------------------------------------------------------------
interface hsmc_in_if;
    logic                                valid;
    logic                                ready;
    logic [hsmc_pkg::RAW_W-1:0]          compass_raw;
    logic [hsmc_pkg::DEG_W-1:0]          desired_heading;
    logic [hsmc_pkg::DIST_W-1:0]         distance_to_target;
    logic [hsmc_pkg::TIME_W-1:0]         now_ms;

    modport source (output valid, compass_raw, desired_heading, distance_to_target, now_ms,
                    input ready);
    modport sink   (input valid, compass_raw, desired_heading, distance_to_target, now_ms,
                    output ready);
endinterface

interface hsmc_out_if;
    logic                                valid;
    logic                                ready;
    logic [hsmc_pkg::BYTE_W-1:0]         out_byte;
    logic [hsmc_pkg::MODE_W-1:0]         drive_mode;
    logic                                last;

    modport source (output valid, out_byte, drive_mode, last, input ready);
    modport sink   (input valid, out_byte, drive_mode, last, output ready);
endinterface

interface hsmc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hsmc_pkg::CIDX_W-1:0]         index;
    logic [hsmc_pkg::CDAT_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/hsmc_div.sv]
// ----------------------------------------------------------------------------
// hsmc_div
// restoring divider, one quotient bit per cycle, small dividend by time step
// ----------------------------------------------------------------------------
module hsmc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hsmc_pkg::DEG_W-1:0]    i_num,
    input  logic [hsmc_pkg::TIME_W-1:0]   i_den,
    output logic                          o_done,
    output logic [hsmc_pkg::DEG_W-1:0]    o_quo
);
    localparam int NW = hsmc_pkg::DEG_W;
    localparam int TW = hsmc_pkg::TIME_W;

    logic                  r_busy;
    logic                  r_done;
    logic [3:0]            r_cnt;
    logic [NW-1:0]         r_num;
    logic [NW-1:0]         r_rem;
    logic [NW-1:0]         r_quo;
    logic [TW-1:0]         r_den;
    logic [NW:0]           trial;
    logic                  fits;
    logic [NW:0]           diff;

    // trial subtract of the shifted remainder
    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        fits  = {{(TW-NW-1){1'b0}}, trial} >= r_den;
        diff  = trial - r_den[NW:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= fits ? diff[NW-1:0] : trial[NW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

[rtl/core/hsmc_mul.sv]
// ----------------------------------------------------------------------------
// hsmc_mul
// shared unsigned 32 by 32 multiplier with a registered product
// ----------------------------------------------------------------------------
module hsmc_mul (
    input  logic                           i_clk,
    input  logic [hsmc_pkg::GAIN_W-1:0]    i_a,
    input  logic [hsmc_pkg::GAIN_W-1:0]    i_b,
    output logic [hsmc_pkg::PROD_W-1:0]    o_prod
);
    logic [hsmc_pkg::PROD_W-1:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_prod = r_prod;
endmodule

[rtl/core/heading_steering_motor_commander_top.sv]
// ----------------------------------------------------------------------------
// heading_steering_motor_commander_top
// compass heading error to dual motor serial commands, stop/straight/PID turn
// ----------------------------------------------------------------------------
// Usage
//   i_in  : one beat per control update (compass, bearing, distance, time).
//   o_out : eight command beats per update, two 4-byte motor packets, last
//           marks the eighth beat; drive_mode is the same on all eight.
//   i_cfg : register writes, always ready; write only while the block idles.
// Sequence
//   stop and straight: S_HEAD, S_ERR and S_DECIDE lie between the input beat
//   and the first beat. turn: after S_DECIDE come two runs of the shared
//   divider (S_DIVD_GO/WAIT, S_DIVQ_GO/WAIT), S_INTEG, six steps of the shared
//   multiplier in S_MUL, and S_SPEED. The beats then follow back to back.
//   i_in.ready is high only while idle, so one item is in flight at a time.
// Reset
//   registers return to their defaults, the PID state (last error, last
//   turn time, integral) clears and the block comes up idle.
// Stalls
//   a low o_out.ready holds the current beat; the block waits without loss.
// ----------------------------------------------------------------------------
module heading_steering_motor_commander_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsmc_in_if.sink           i_in,
    hsmc_out_if.source        o_out,
    hsmc_cfg_if.sink          i_cfg
);
    localparam int DEG_W  = hsmc_pkg::DEG_W;
    localparam int ACC_W  = hsmc_pkg::ACC_W;
    localparam int INT_W  = hsmc_pkg::INTEG_W;
    localparam int PROD_W = hsmc_pkg::PROD_W;
    localparam int TMAG_W = hsmc_pkg::TMAG_W;

    hsmc_pkg::t_state r_state, n_state;

    // configuration registers
    logic [hsmc_pkg::GAIN_W-1:0]  r_prop_gain, r_deriv_gain, r_integ_gain;
    logic [DEG_W-1:0]             r_offset;
    logic [hsmc_pkg::NEAR_W-1:0]  r_near_dist;
    logic [hsmc_pkg::SPD_W-1:0]   r_near_speed, r_far_speed;
    logic [hsmc_pkg::MOTOR_W-1:0] r_first_mot;

    // item registers
    logic [hsmc_pkg::RAW_W-1:0]   r_raw;
    logic [DEG_W-1:0]             r_want;
    logic [hsmc_pkg::DIST_W-1:0]  r_dist;
    logic [hsmc_pkg::TIME_W-1:0]  r_now;
    logic [DEG_W-1:0]             r_heading;
    logic signed [DEG_W-1:0]      r_err;
    logic [hsmc_pkg::TIME_W-1:0]  r_dt;
    logic [DEG_W-1:0]             r_dmag, r_qmag;
    logic                         r_dneg, r_qneg;
    logic [2:0]                   r_mstep;
    logic signed [ACC_W-1:0]      r_acc;
    logic [PROD_W-1:0]            r_prod_hi;
    logic [TMAG_W-1:0]            r_tmag;
    logic [hsmc_pkg::SPD_W-1:0]   r_mag;
    logic                         r_neg1, r_neg2;
    hsmc_pkg::t_mode              r_mode;
    logic [2:0]                   r_beat;

    // PID state
    logic signed [DEG_W-1:0]      r_prior;
    logic [hsmc_pkg::TIME_W-1:0]  r_last_ms;
    logic signed [INT_W-1:0]      r_integ;

    // combinational helpers
    logic [24:0]                  quot10;
    logic [10:0]                  hsum;
    logic [9:0]                   esum;
    logic [DEG_W-1:0]             emod;
    logic [DEG_W-1:0]             emag;
    logic signed [DEG_W:0]        dnum;
    logic [DEG_W-1:0]             dnum_mag;
    logic [hsmc_pkg::TIME_W-1:0]  dt_raw;
    logic signed [DEG_W:0]        q_signed;
    logic signed [INT_W:0]        isum;
    logic                         ineg;
    logic [INT_W-1:0]             imag;
    logic [31:0]                  mul_a, mul_b;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W-1:0]            tsum;
    logic [ACC_W-1:0]             amag;
    logic [13:0]                  spd_whole;
    logic [hsmc_pkg::SPD_W-1:0]   straight_spd;
    logic                         div_start, div_done;
    logic [DEG_W-1:0]             div_num, div_quo;
    logic [hsmc_pkg::MOTOR_W-1:0] motor_sel;
    logic                         neg_sel;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= hsmc_pkg::RST_PROP_GAIN;
            r_deriv_gain <= hsmc_pkg::RST_DERIV_GAIN;
            r_integ_gain <= hsmc_pkg::RST_INTEG_GAIN;
            r_offset     <= hsmc_pkg::RST_OFFSET;
            r_near_dist  <= hsmc_pkg::RST_NEAR_DIST;
            r_near_speed <= hsmc_pkg::RST_NEAR_SPEED;
            r_far_speed  <= hsmc_pkg::RST_FAR_SPEED;
            r_first_mot  <= hsmc_pkg::RST_FIRST_MOT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hsmc_pkg::CFG_PROP_GAIN:  r_prop_gain  <= i_cfg.data;
                hsmc_pkg::CFG_DERIV_GAIN: r_deriv_gain <= i_cfg.data;
                hsmc_pkg::CFG_INTEG_GAIN: r_integ_gain <= i_cfg.data;
                hsmc_pkg::CFG_OFFSET:     r_offset     <= i_cfg.data[DEG_W-1:0];
                hsmc_pkg::CFG_NEAR_DIST:  r_near_dist  <= i_cfg.data[hsmc_pkg::NEAR_W-1:0];
                hsmc_pkg::CFG_NEAR_SPEED: r_near_speed <= i_cfg.data[hsmc_pkg::SPD_W-1:0];
                hsmc_pkg::CFG_FAR_SPEED:  r_far_speed  <= i_cfg.data[hsmc_pkg::SPD_W-1:0];
                hsmc_pkg::CFG_FIRST_MOT:  r_first_mot  <= i_cfg.data[hsmc_pkg::MOTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // heading, error, divider operands and integral update
    always_comb begin
        quot10 = {13'd0, r_raw} * {12'd0, hsmc_pkg::RECIP10};
        hsum   = {2'b0, quot10[24:16]} + 11'd720 - {2'b0, r_offset};
        esum   = {1'b0, r_want} + 10'd360 - {1'b0, r_heading};
        if (esum >= 10'd720)      emod = 9'(esum - 10'd720);
        else if (esum >= 10'd360) emod = 9'(esum - 10'd360);
        else                      emod = esum[8:0];
        emag     = r_err[DEG_W-1] ? 9'(-r_err) : r_err;
        dnum     = {r_err[DEG_W-1], r_err} - {r_prior[DEG_W-1], r_prior};
        dnum_mag = dnum[DEG_W] ? 9'(-dnum) : dnum[DEG_W-1:0];
        dt_raw   = r_now - r_last_ms;
        div_num  = (r_state == hsmc_pkg::S_DIVD_GO) ? dnum_mag : emag;
        div_start = (r_state == hsmc_pkg::S_DIVD_GO) || (r_state == hsmc_pkg::S_DIVQ_GO);
        q_signed = r_qneg ? -$signed({1'b0, r_qmag}) : $signed({1'b0, r_qmag});
        isum     = {r_integ[INT_W-1], r_integ}
                 + {{(INT_W-DEG_W-16){q_signed[DEG_W]}}, q_signed, 16'd0};
        ineg     = r_integ[INT_W-1];
        imag     = ineg ? 48'(-r_integ) : r_integ;
        straight_spd = (r_dist[23:8] < r_near_dist) ? r_near_speed : r_far_speed;
        amag      = r_acc[ACC_W-1] ? 44'(-r_acc) : r_acc;
        spd_whole = amag[43:30];
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (r_mstep)
            3'd0:    begin mul_a = r_prop_gain;  mul_b = {23'd0, emag};           end
            3'd1:    begin mul_a = r_deriv_gain; mul_b = {23'd0, r_dmag};         end
            3'd2:    begin mul_a = r_integ_gain; mul_b = imag[47:16];             end
            3'd3:    begin mul_a = r_integ_gain; mul_b = {16'd0, imag[15:0]};     end
            default: begin mul_a = '0;           mul_b = '0;                      end
        endcase
        tsum = r_prod_hi + {16'd0, prod[63:16]};
    end

    hsmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    hsmc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= hsmc_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsmc_pkg::S_IDLE:      if (i_in.valid) n_state = hsmc_pkg::S_HEAD;
            hsmc_pkg::S_HEAD:      n_state = hsmc_pkg::S_ERR;
            hsmc_pkg::S_ERR:       n_state = hsmc_pkg::S_DECIDE;
            hsmc_pkg::S_DECIDE: begin
                if (r_dist < 24'd256)
                    n_state = hsmc_pkg::S_OUT;
                else if (r_err >= -9'sd2 && r_err <= 9'sd2)
                    n_state = hsmc_pkg::S_OUT;
                else
                    n_state = hsmc_pkg::S_DIVD_GO;
            end
            hsmc_pkg::S_DIVD_GO:   n_state = hsmc_pkg::S_DIVD_WAIT;
            hsmc_pkg::S_DIVD_WAIT: if (div_done) n_state = hsmc_pkg::S_DIVQ_GO;
            hsmc_pkg::S_DIVQ_GO:   n_state = hsmc_pkg::S_DIVQ_WAIT;
            hsmc_pkg::S_DIVQ_WAIT: if (div_done) n_state = hsmc_pkg::S_INTEG;
            hsmc_pkg::S_INTEG:     n_state = hsmc_pkg::S_MUL;
            hsmc_pkg::S_MUL:       if (r_mstep == 3'd5) n_state = hsmc_pkg::S_SPEED;
            hsmc_pkg::S_SPEED:     n_state = hsmc_pkg::S_OUT;
            hsmc_pkg::S_OUT:
                if (o_out.ready && r_beat == 3'd7) n_state = hsmc_pkg::S_IDLE;
            default:               n_state = hsmc_pkg::S_IDLE;
        endcase
    end

    // PID state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior   <= '0;
            r_last_ms <= '0;
            r_integ   <= '0;
        end else if (r_state == hsmc_pkg::S_INTEG) begin
            r_prior   <= r_err;
            r_last_ms <= r_now;
            if (isum[INT_W] != isum[INT_W-1])
                r_integ <= isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
            else
                r_integ <= isum[INT_W-1:0];
        end
    end

    // beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (r_state == hsmc_pkg::S_OUT && o_out.ready) begin
            r_beat <= r_beat + 3'd1;
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            hsmc_pkg::S_IDLE: begin
                r_raw   <= i_in.compass_raw;
                r_want  <= i_in.desired_heading;
                r_dist  <= i_in.distance_to_target;
                r_now   <= i_in.now_ms;
                r_mstep <= '0;
            end
            hsmc_pkg::S_HEAD: begin
                if (hsum >= 11'd1080)     r_heading <= 9'(hsum - 11'd1080);
                else if (hsum >= 11'd720) r_heading <= 9'(hsum - 11'd720);
                else if (hsum >= 11'd360) r_heading <= 9'(hsum - 11'd360);
                else                      r_heading <= hsum[8:0];
            end
            hsmc_pkg::S_ERR: begin
                r_err <= (emod > 9'd180) ? $signed(9'(emod - 9'd360)) : $signed(emod);
            end
            hsmc_pkg::S_DECIDE: begin
                r_dt <= (dt_raw == '0) ? 32'd1 : dt_raw;
                if (r_dist < 24'd256) begin
                    r_mode <= hsmc_pkg::MODE_STOP;
                    r_mag  <= '0;
                    r_neg1 <= 1'b0;
                    r_neg2 <= 1'b0;
                end else begin
                    r_mode <= hsmc_pkg::MODE_STRAIGHT;
                    r_mag  <= straight_spd;
                    r_neg1 <= straight_spd != '0;
                    r_neg2 <= straight_spd != '0;
                end
            end
            hsmc_pkg::S_DIVD_GO: r_dneg <= dnum[DEG_W];
            hsmc_pkg::S_DIVD_WAIT: if (div_done) r_dmag <= div_quo;
            hsmc_pkg::S_DIVQ_GO: r_qneg <= r_err[DEG_W-1];
            hsmc_pkg::S_DIVQ_WAIT: if (div_done) r_qmag <= div_quo;
            hsmc_pkg::S_MUL: begin
                r_mstep <= r_mstep + 3'd1;
                case (r_mstep)
                    // proportional term
                    3'd1: r_acc <= r_err[DEG_W-1] ? -$signed(prod[ACC_W-1:0])
                                                  :  $signed(prod[ACC_W-1:0]);
                    // derivative term
                    3'd2: r_acc <= r_dneg ? r_acc - $signed(prod[ACC_W-1:0])
                                          : r_acc + $signed(prod[ACC_W-1:0]);
                    3'd3: r_prod_hi <= prod;
                    // integral magnitude, limited
                    3'd4: r_tmag <= (tsum > {23'd0, hsmc_pkg::TERM_LIMIT})
                                    ? hsmc_pkg::TERM_LIMIT : tsum[TMAG_W-1:0];
                    3'd5: r_acc <= ineg ? r_acc - $signed({3'b0, r_tmag})
                                        : r_acc + $signed({3'b0, r_tmag});
                    default: ;
                endcase
            end
            hsmc_pkg::S_SPEED: begin
                r_mode <= hsmc_pkg::MODE_TURN;
                r_mag  <= (spd_whole > 14'(hsmc_pkg::SPEED_MAX))
                          ? hsmc_pkg::SPEED_MAX : spd_whole[hsmc_pkg::SPD_W-1:0];
                r_neg1 <=  r_acc[ACC_W-1] && (spd_whole != '0);
                r_neg2 <= !r_acc[ACC_W-1] && (spd_whole != '0);
            end
            default: ;
        endcase
    end

    // result beats
    assign i_in.ready = (r_state == hsmc_pkg::S_IDLE);
    assign motor_sel  = r_beat[2] ? r_first_mot + 6'd1 : r_first_mot;
    assign neg_sel    = r_beat[2] ? r_neg2 : r_neg1;

    always_comb begin
        o_out.valid      = (r_state == hsmc_pkg::S_OUT);
        o_out.drive_mode = r_mode;
        o_out.last       = (r_beat == 3'd7);
        unique case (r_beat[1:0])
            hsmc_pkg::POS_START:  o_out.out_byte = hsmc_pkg::START_BYTE;
            hsmc_pkg::POS_DEVICE: o_out.out_byte = hsmc_pkg::DEVICE_BYTE;
            hsmc_pkg::POS_MOTOR:  o_out.out_byte = {1'b0, motor_sel, !neg_sel};
            hsmc_pkg::POS_SPEED:  o_out.out_byte = {1'b0, r_mag};
            default:              o_out.out_byte = hsmc_pkg::START_BYTE;
        endcase
    end
endmodule

[rtl/core/hsmc_chk.sv]
// ----------------------------------------------------------------------------
// hsmc_chk
// port-level checks of the commander, attached to the top level
// ----------------------------------------------------------------------------
module hsmc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_last,
    input logic [1:0] i_out_mode
);
    // results never overlap the acceptance of a new item
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("input ready while result beats pending");

    // an accepted item closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after accept");

    // the run ends at the last beat
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("beats continue after last");

    // beats of one run follow back to back with one mode
    a_mode_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_valid && $stable(i_out_mode)))
        else $error("run broken or mode changed");

    // mode code meaningful
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_mode != 2'd3))
        else $error("undefined drive mode");
endmodule

bind heading_steering_motor_commander_top hsmc_chk u_hsmc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last),
    .i_out_mode  (o_out.drive_mode)
);

[sim/heading_steering_motor_commander_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_steering_motor_commander_top_tb
// drives compass items and register writes, predicts the eight command beats
// of every item with an own fixed-point model and checks them field by field
// ----------------------------------------------------------------------------
module heading_steering_motor_commander_top_tb;

    typedef struct packed {
        logic [hsmc_pkg::BYTE_W-1:0] cmd;
        hsmc_pkg::t_mode             mode;
        logic                        fin;
    } t_beat;

    // predicted motor command stream and steering state
    class motor_cmd_board;
        t_beat      pending[$];
        int         mismatches;
        logic [31:0] kp, kd, ki;
        logic [8:0]  offset_deg;
        logic [15:0] near_m;
        logic [6:0]  slow_spd, fast_spd;
        logic [5:0]  motor_a;
        longint      last_err;
        logic [31:0] turn_ms;
        longint      integ;

        function void clear_state();
            kp = hsmc_pkg::RST_PROP_GAIN; kd = hsmc_pkg::RST_DERIV_GAIN;
            ki = hsmc_pkg::RST_INTEG_GAIN;
            offset_deg = hsmc_pkg::RST_OFFSET; near_m = hsmc_pkg::RST_NEAR_DIST;
            slow_spd = hsmc_pkg::RST_NEAR_SPEED; fast_spd = hsmc_pkg::RST_FAR_SPEED;
            motor_a = hsmc_pkg::RST_FIRST_MOT;
            last_err = 0; turn_ms = 0; integ = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [hsmc_pkg::CIDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                hsmc_pkg::CFG_PROP_GAIN:  kp = val;
                hsmc_pkg::CFG_DERIV_GAIN: kd = val;
                hsmc_pkg::CFG_INTEG_GAIN: ki = val;
                hsmc_pkg::CFG_OFFSET:     offset_deg = val[8:0];
                hsmc_pkg::CFG_NEAR_DIST:  near_m = val[15:0];
                hsmc_pkg::CFG_NEAR_SPEED: slow_spd = val[6:0];
                hsmc_pkg::CFG_FAR_SPEED:  fast_spd = val[6:0];
                hsmc_pkg::CFG_FIRST_MOT:  motor_a = val[5:0];
                default: ;
            endcase
        endfunction

        function void push_motor(logic [5:0] mot, longint spd, hsmc_pkg::t_mode md,
                                 bit second);
            t_beat b;
            logic dir;
            longint mag;
            dir = (spd < 0) ? 1'b0 : 1'b1;
            mag = (spd < 0) ? -spd : spd;
            if (mag > 127) mag = 127;
            b.mode = md; b.fin = 1'b0;
            b.cmd = hsmc_pkg::START_BYTE; pending.push_back(b);
            b.cmd = hsmc_pkg::DEVICE_BYTE; pending.push_back(b);
            b.cmd = {1'b0, mot, dir}; pending.push_back(b);
            b.cmd = mag[7:0]; b.fin = second; pending.push_back(b);
        endfunction

        // work out the eight beats of one accepted item
        function void note_item(logic [11:0] raw, logic [8:0] want, logic [23:0] span,
                                logic [31:0] now);
            longint hd, e, dt, dq, q, inc, pt, dtm, tot, s;
            longint imax, imin;
            logic [63:0] imag, tmag;
            logic [5:0] motor_b;
            imax = 64'sh7FFF_FFFF_FFFF; imin = -imax - 1;
            motor_b = motor_a + 6'd1;
            hd = (longint'(raw / 10) - longint'(offset_deg) + 720) % 360;
            e = (longint'(want) - hd + 360) % 360;
            if (e > 180) e -= 360;
            if (span < 256) begin
                push_motor(motor_a, 0, hsmc_pkg::MODE_STOP, 0);
                push_motor(motor_b, 0, hsmc_pkg::MODE_STOP, 1);
                return;
            end
            if (e >= -2 && e <= 2) begin
                s = (span[23:8] < near_m) ? longint'(slow_spd) : longint'(fast_spd);
                push_motor(motor_a, -s, hsmc_pkg::MODE_STRAIGHT, 0);
                push_motor(motor_b, -s, hsmc_pkg::MODE_STRAIGHT, 1);
                return;
            end
            dt = longint'(now - turn_ms);
            if (dt == 0) dt = 1;
            dq = (e - last_err) / dt;
            q = e / dt;
            inc = q * 65536;
            if (inc > 0 && integ > imax - inc) integ = imax;
            else if (inc < 0 && integ < imin - inc) integ = imin;
            else integ += inc;
            pt = longint'(kp) * e;
            dtm = longint'(kd) * dq;
            imag = (integ < 0) ? -integ : integ;
            tmag = 64'(ki) * (imag >> 16) + ((64'(ki) * imag[15:0]) >> 16);
            if (tmag > 64'h100_0000_0000) tmag = 64'h100_0000_0000;
            tot = pt + dtm + ((integ < 0) ? -longint'(tmag) : longint'(tmag));
            s = (tot < 0) ? -((-tot) >>> 30) : (tot >>> 30);
            if (s > 127) s = 127;
            if (s < -127) s = -127;
            push_motor(motor_a, s, hsmc_pkg::MODE_TURN, 0);
            push_motor(motor_b, -s, hsmc_pkg::MODE_TURN, 1);
            last_err = e;
            turn_ms = now;
        endfunction

        function void check_beat(t_beat got);
            t_beat exp_b;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %h mode %0d last %b", got.cmd, got.mode, got.fin);
                return;
            end
            exp_b = pending.pop_front();
            if (exp_b !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch: exp byte %h mode %0d last %b, got %h %0d %b",
                             exp_b.cmd, exp_b.mode, exp_b.fin, got.cmd, got.mode, got.fin);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   quiet = 0;

    hsmc_in_if  in_ch();
    hsmc_out_if out_ch();
    hsmc_cfg_if cfg_ch();

    motor_cmd_board board = new();

    heading_steering_motor_commander_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    // sample result beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_beat({out_ch.out_byte, hsmc_pkg::t_mode'(out_ch.drive_mode),
                              out_ch.last});
    end

    // random receiver stalls in bursts
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [hsmc_pkg::CIDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.write_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(logic [11:0] raw, logic [8:0] want, logic [23:0] span,
                             logic [31:0] now);
        int n;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.compass_raw <= raw;
        in_ch.desired_heading <= want;
        in_ch.distance_to_target <= span;
        in_ch.now_ms <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_item(raw, want, span, now);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // wait until every beat is out, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic random_items(int cnt);
        logic [31:0] t;
        logic [23:0] d;
        int k;
        t = $urandom;
        for (k = 0; k < cnt; k++) begin
            t = t + $urandom_range(0, 3) * (($urandom_range(0, 4) == 0) ? 32'd1 : 32'd50);
            if ($urandom_range(0, 9) == 0) t = $urandom;
            case ($urandom_range(0, 5))
                0: d = 24'($urandom_range(0, 255));
                1: d = 24'($urandom);
                default: d = 24'($urandom_range(256, 20 * 256));
            endcase
            send_item(12'($urandom_range(0, 4095)), 9'($urandom_range(0, 511)), d, t);
        end
    endtask

    // stimulus
    initial begin
        in_ch.valid = 1'b0;
        in_ch.compass_raw = '0;
        in_ch.desired_heading = '0;
        in_ch.distance_to_target = '0;
        in_ch.now_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = hsmc_pkg::CFG_PROP_GAIN;
        cfg_ch.data = '0;
        board.clear_state();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: stop, straight near and far, turns, wrap, zero time step
        send_item(12'd0, 9'd0, 24'd255, 32'd0);
        send_item(12'd4095, 9'd511, 24'd0, 32'hFFFF_FFFF);
        send_item(12'd30, 9'd2, 24'd256, 32'd10);
        send_item(12'd30, 9'd358, 24'hFFFFFF, 32'd20);
        send_item(12'd30, 9'd1, 24'd1024, 32'd30);
        send_item(12'd30, 9'd3, 24'd1000, 32'd50);
        send_item(12'd30, 9'd183, 24'd1000, 32'd50);
        send_item(12'd30, 9'd184, 24'd1000, 32'd100);
        send_item(12'd3599, 9'd359, 24'd1000, 32'd100);
        send_item(12'd1800, 9'd0, 24'd1000, 32'hFFFF_FFF0);
        send_item(12'd900, 9'd100, 24'd1000, 32'd5);
        drain();

        // extremes of gains and other settings
        write_reg(hsmc_pkg::CFG_PROP_GAIN, 32'hFFFF_FFFF);
        write_reg(hsmc_pkg::CFG_DERIV_GAIN, 32'hFFFF_FFFF);
        write_reg(hsmc_pkg::CFG_INTEG_GAIN, 32'hFFFF_FFFF);
        write_reg(hsmc_pkg::CFG_OFFSET, 32'd511);
        write_reg(hsmc_pkg::CFG_NEAR_DIST, 32'hFFFF);
        write_reg(hsmc_pkg::CFG_NEAR_SPEED, 32'd127);
        write_reg(hsmc_pkg::CFG_FAR_SPEED, 32'd0);
        write_reg(hsmc_pkg::CFG_FIRST_MOT, 32'd63);
        write_reg(4'd12, 32'hDEAD_BEEF);
        send_item(12'd0, 9'd0, 24'd300, 32'd7);
        send_item(12'd100, 9'd300, 24'd300, 32'd7);
        send_item(12'd100, 9'd20, 24'd300, 32'd8);
        random_items(80);
        drain();

        write_reg(hsmc_pkg::CFG_PROP_GAIN, 32'd0);
        write_reg(hsmc_pkg::CFG_DERIV_GAIN, 32'd0);
        write_reg(hsmc_pkg::CFG_INTEG_GAIN, 32'd0);
        write_reg(hsmc_pkg::CFG_OFFSET, 32'd0);
        write_reg(hsmc_pkg::CFG_NEAR_DIST, 32'd0);
        write_reg(hsmc_pkg::CFG_NEAR_SPEED, 32'd0);
        write_reg(hsmc_pkg::CFG_FAR_SPEED, 32'd127);
        write_reg(hsmc_pkg::CFG_FIRST_MOT, 32'd0);
        random_items(60);
        drain();

        // random settings
        repeat (3) begin
            write_reg(hsmc_pkg::CFG_PROP_GAIN, $urandom);
            write_reg(hsmc_pkg::CFG_DERIV_GAIN, $urandom);
            write_reg(hsmc_pkg::CFG_INTEG_GAIN, $urandom_range(0, 1 << 20));
            write_reg(hsmc_pkg::CFG_OFFSET, $urandom_range(0, 359));
            write_reg(hsmc_pkg::CFG_NEAR_DIST, $urandom_range(0, 20));
            write_reg(hsmc_pkg::CFG_NEAR_SPEED, $urandom_range(0, 127));
            write_reg(hsmc_pkg::CFG_FAR_SPEED, $urandom_range(0, 127));
            write_reg(hsmc_pkg::CFG_FIRST_MOT, $urandom_range(0, 63));
            random_items(60);
            drain();
        end

        // no idling at the end
        quiet = 1;
        random_items(80);
        drain();
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("heading_steering_motor_commander_top verification clean");
        else
            $display("heading_steering_motor_commander_top verification failed");
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("heading_steering_motor_commander_top verification failed");
        $finish;
    end
endmodule
